// ===== hw/rtl/sidx_pkg.sv =====
// ----------------------------------------------------------------------------
// sidx_pkg: shared types and constants for the slice index normalizer
// Word layouts, error codes, item kinds and datapath widths.
// ----------------------------------------------------------------------------
package sidx_pkg;

	// defaults for top-level parameters
	localparam int INDEX_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 4;

	// field widths
	localparam int LEN_W  = 31;             // dimension length
	localparam int VAL_W  = 32;             // signed start/stop/step
	localparam int CNT_W  = 31;             // element count
	localparam int ERR_W  = 3;
	localparam int SPAN_W = 31;             // dividend of the count division
	localparam int MAG_W  = SPAN_W + 1;     // step magnitude, up to 2^31
	localparam int WIDE_W = VAL_W + 2;      // room for value + length

	// item kinds
	localparam logic CMD_SLICE = 1'b0;
	localparam logic CMD_INDEX = 1'b1;

	// error codes
	localparam logic [ERR_W-1:0] ERR_OK    = 3'd0;
	localparam logic [ERR_W-1:0] ERR_LEN   = 3'd1;
	localparam logic [ERR_W-1:0] ERR_EMPTY = 3'd2;
	localparam logic [ERR_W-1:0] ERR_STEP  = 3'd3;
	localparam logic [ERR_W-1:0] ERR_RANGE = 3'd4;

	typedef struct packed {
		logic             cmd;
		logic [LEN_W-1:0] dim_length;
		logic             start_given;
		logic [VAL_W-1:0] start_value;
		logic             stop_given;
		logic [VAL_W-1:0] stop_value;
		logic             step_given;
		logic [VAL_W-1:0] step_value;
	} item_t;

	typedef struct packed {
		logic [LEN_W-1:0] norm_start;
		logic [VAL_W-1:0] norm_stop;
		logic             stop_is_default;
		logic [VAL_W-1:0] norm_step;
		logic [CNT_W-1:0] element_count;
		logic [ERR_W-1:0] error_code;
	} result_t;

	// classified word handed from front to back
	typedef struct packed {
		logic [LEN_W-1:0]  norm_start;
		logic [VAL_W-1:0]  norm_stop;
		logic              stop_is_default;
		logic [VAL_W-1:0]  norm_step;
		logic [ERR_W-1:0]  error_code;
		logic [SPAN_W-1:0] span;
		logic [MAG_W-1:0]  mag;
	} job_t;

endpackage

// ===== hw/rtl/sidx_front.sv =====
// ----------------------------------------------------------------------------
// sidx_front: input stage and classifier
// Wraps negative bounds in stage 1, then clamps, checks errors and forms
// the span and step magnitude for the count division.
// ----------------------------------------------------------------------------
module sidx_front #(
	parameter int INDEX_WIDTH = sidx_pkg::INDEX_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  sidx_pkg::item_t item,
	output logic            job_valid,
	input  logic            job_ready,
	output sidx_pkg::job_t  job
);
	import sidx_pkg::*;

	localparam int EFF_W = (INDEX_WIDTH < VAL_W) ? INDEX_WIDTH : VAL_W;
	localparam int SH    = VAL_W - EFF_W;

	// read the low EFF_W bits as two's complement
	function automatic logic signed [VAL_W-1:0] sext_idx(input logic [VAL_W-1:0] v);
		sext_idx = $signed(v << SH) >>> SH;
	endfunction

	logic signed [VAL_W-1:0]  sv, stop_sv, step_sv;
	logic signed [WIDE_W-1:0] n_w, sv_w, stop_sv_w, start_w_d, stop_w_d;
	logic signed [VAL_W-1:0]  step_d;
	logic                     use_sv, neg_d;

	logic                     valid_s1;
	logic                     is_index_s1, stop_given_s1;
	logic [LEN_W-1:0]         n_s1;
	logic signed [VAL_W-1:0]  step_s1;
	logic signed [WIDE_W-1:0] start_w_s1, stop_w_s1;

	// stage 1: defaults for start, wrap of negative bounds
	always_comb begin
		sv        = sext_idx(item.start_value);
		stop_sv   = sext_idx(item.stop_value);
		step_sv   = sext_idx(item.step_value);
		n_w       = WIDE_W'(item.dim_length);
		sv_w      = WIDE_W'(sv);
		stop_sv_w = WIDE_W'(stop_sv);
		step_d    = item.step_given ? step_sv : VAL_W'(1);
		neg_d     = step_d[VAL_W-1];
		use_sv    = (item.cmd == CMD_INDEX) || item.start_given;
		if (use_sv) begin
			start_w_d = sv_w[WIDE_W-1] ? (sv_w + n_w) : sv_w;
		end else begin
			start_w_d = neg_d ? (n_w - WIDE_W'(1)) : '0;
		end
		stop_w_d = stop_sv_w[WIDE_W-1] ? (stop_sv_w + n_w) : stop_sv_w;
	end

	assign item_stall = valid_s1 && !job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			is_index_s1   <= item.cmd;
			stop_given_s1 <= item.stop_given;
			n_s1          <= item.dim_length;
			step_s1       <= step_d;
			start_w_s1    <= start_w_d;
			stop_w_s1     <= stop_w_d;
		end
	end

	// stage 2: clamp, error checks, span
	logic signed [WIDE_W-1:0] n2, nm1, st, sp, span_w;
	logic                     neg2;

	always_comb begin
		n2     = WIDE_W'(n_s1);
		nm1    = n2 - WIDE_W'(1);
		neg2   = step_s1[VAL_W-1];
		st     = '0;
		sp     = '0;
		span_w = '0;
		job    = '0;
		job.mag = MAG_W'(1);
		if (is_index_s1) begin
			if (!start_w_s1[WIDE_W-1] && (start_w_s1 < n2)) begin
				job.norm_start = start_w_s1[LEN_W-1:0];
				job.span       = SPAN_W'(1);
				job.error_code = ERR_OK;
			end else begin
				job.error_code = ERR_RANGE;
			end
		end else if (n_s1 == '0) begin
			job.error_code = ERR_LEN;
		end else if (step_s1 == '0) begin
			job.error_code = ERR_STEP;
		end else if (!neg2) begin
			st = start_w_s1[WIDE_W-1] ? '0 : start_w_s1;
			if (!stop_given_s1) begin
				sp = n2;
			end else begin
				sp = (stop_w_s1 > n2) ? n2 : stop_w_s1;
			end
			span_w = sp - st;
			if (st >= sp) begin
				job.error_code = ERR_EMPTY;
			end else begin
				job.norm_start = st[LEN_W-1:0];
				job.norm_stop  = sp[VAL_W-1:0];
				job.norm_step  = step_s1;
				job.span       = span_w[SPAN_W-1:0];
				job.mag        = MAG_W'(step_s1);
				job.error_code = ERR_OK;
			end
		end else begin
			st = (start_w_s1 > nm1) ? nm1 : start_w_s1;
			if (!stop_given_s1) begin
				sp = -WIDE_W'(1);
			end else begin
				sp = (stop_w_s1 < -WIDE_W'(1)) ? -WIDE_W'(1) : stop_w_s1;
			end
			span_w = st - sp;
			if (sp >= st) begin
				job.error_code = ERR_EMPTY;
			end else begin
				job.norm_start      = st[LEN_W-1:0];
				job.norm_stop       = sp[VAL_W-1:0];
				job.stop_is_default = (sp == -WIDE_W'(1));
				job.norm_step       = step_s1;
				job.span            = span_w[SPAN_W-1:0];
				job.mag             = MAG_W'(-step_s1);
				job.error_code      = ERR_OK;
			end
		end
	end

	assign job_valid = valid_s1;

endmodule

// ===== hw/rtl/sidx_queue.sv =====
// ----------------------------------------------------------------------------
// sidx_queue: short FIFO between classifier and divider
// Register file with read and write pointers and an occupancy count.
// ----------------------------------------------------------------------------
module sidx_queue #(
	parameter int DEPTH = sidx_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  sidx_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop,
	output sidx_pkg::job_t pop_job
);
	import sidx_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	job_t            entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [AW:0]     count_q;
	logic            do_push, do_pop;

	assign push_ready = (count_q != (AW+1)'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_job    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ===== hw/rtl/sidx_back.sv =====
// ----------------------------------------------------------------------------
// sidx_back: pipelined count divider and result register
// Restoring division, one quotient bit per stage, ceiling at the end.
// ----------------------------------------------------------------------------
module sidx_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_pop,
	input  sidx_pkg::job_t    job,
	output logic              result_valid,
	input  logic              result_stall,
	output sidx_pkg::result_t result
);
	import sidx_pkg::*;

	localparam int STAGES = SPAN_W;

	typedef struct packed {
		logic [LEN_W-1:0] norm_start;
		logic [VAL_W-1:0] norm_stop;
		logic             stop_is_default;
		logic [VAL_W-1:0] norm_step;
		logic [ERR_W-1:0] error_code;
	} meta_t;

	logic              vld_q  [STAGES];
	logic [SPAN_W-1:0] rem_q  [STAGES];
	logic [SPAN_W-1:0] dvd_q  [STAGES];
	logic [SPAN_W-1:0] quo_q  [STAGES];
	logic [MAG_W-1:0]  div_q  [STAGES];
	meta_t             meta_q [STAGES];

	logic [SPAN_W-1:0] rem_d  [STAGES];
	logic [SPAN_W-1:0] dvd_d  [STAGES];
	logic [SPAN_W-1:0] quo_d  [STAGES];
	logic [MAG_W-1:0]  div_d  [STAGES];
	meta_t             meta_d [STAGES];

	logic [SPAN_W-1:0] rem_in  [STAGES];
	logic [SPAN_W-1:0] dvd_in  [STAGES];
	logic [SPAN_W-1:0] quo_in  [STAGES];
	logic [MAG_W-1:0]  trial   [STAGES];
	logic [MAG_W-1:0]  diff    [STAGES];
	logic              ge      [STAGES];

	logic    adv;
	logic    res_valid_q;
	result_t res_q;
	meta_t   job_meta;

	// whole divider moves unless a finished result is held
	assign adv     = !res_valid_q || !result_stall;
	assign job_pop = adv && job_valid;

	always_comb begin
		job_meta.norm_start      = job.norm_start;
		job_meta.norm_stop       = job.norm_stop;
		job_meta.stop_is_default = job.stop_is_default;
		job_meta.norm_step       = job.norm_step;
		job_meta.error_code      = job.error_code;
	end

	always_comb begin
		for (int i = 0; i < STAGES; i++) begin
			if (i == 0) begin
				rem_in[i]  = '0;
				dvd_in[i]  = job.span;
				quo_in[i]  = '0;
				div_d[i]   = job.mag;
				meta_d[i]  = job_meta;
			end else begin
				rem_in[i]  = rem_q[i-1];
				dvd_in[i]  = dvd_q[i-1];
				quo_in[i]  = quo_q[i-1];
				div_d[i]   = div_q[i-1];
				meta_d[i]  = meta_q[i-1];
			end
			trial[i] = {rem_in[i], dvd_in[i][SPAN_W-1]};
			ge[i]    = (trial[i] >= div_d[i]);
			diff[i]  = trial[i] - div_d[i];
			rem_d[i] = ge[i] ? diff[i][SPAN_W-1:0] : trial[i][SPAN_W-1:0];
			dvd_d[i] = {dvd_in[i][SPAN_W-2:0], 1'b0};
			quo_d[i] = {quo_in[i][SPAN_W-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STAGES; i++) begin
				vld_q[i] <= 1'b0;
			end
			res_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= job_valid;
			for (int i = 1; i < STAGES; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
			res_valid_q <= vld_q[STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < STAGES; i++) begin
				rem_q[i]  <= rem_d[i];
				dvd_q[i]  <= dvd_d[i];
				quo_q[i]  <= quo_d[i];
				div_q[i]  <= div_d[i];
				meta_q[i] <= meta_d[i];
			end
		end
		if (adv && vld_q[STAGES-1]) begin
			res_q.norm_start      <= meta_q[STAGES-1].norm_start;
			res_q.norm_stop       <= meta_q[STAGES-1].norm_stop;
			res_q.stop_is_default <= meta_q[STAGES-1].stop_is_default;
			res_q.norm_step       <= meta_q[STAGES-1].norm_step;
			res_q.error_code      <= meta_q[STAGES-1].error_code;
			// ceiling: round up on a nonzero remainder
			res_q.element_count   <= CNT_W'(quo_q[STAGES-1])
				+ CNT_W'(rem_q[STAGES-1] != '0);
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ===== hw/rtl/slice_index_normalizer.sv =====
// ----------------------------------------------------------------------------
// slice_index_normalizer: per-dimension slice and index normalizer
// Front classifier, word queue and pipelined count divider.
// ----------------------------------------------------------------------------
// Takes one word per cycle while item_stall is low and returns one result
// word per input word, in order. A slice word gets its bounds wrapped,
// clamped and defaulted and its element count computed as the ceiling of
// span over step magnitude; an index word gets its wrapped position and a
// count of one. Errors zero all fields but error_code. Sustained rate is one
// word per clock while nothing stalls; with no stalls a word passes through
// the classifier register, the queue and each of the 31 divider stages (one
// quotient bit each), after which the result register offers it. The
// divider pipeline is what sets the latency. A stall on the result side
// freezes the divider; the queue (QUEUE_DEPTH words) and the classifier keep
// taking input until they fill, then item_stall rises. INDEX_WIDTH sets the
// width in which start, stop and step are read as two's complement (values
// above 32 act as 32).
// ----------------------------------------------------------------------------
module slice_index_normalizer #(
	parameter int INDEX_WIDTH = sidx_pkg::INDEX_WIDTH_DEF,
	parameter int QUEUE_DEPTH = sidx_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  sidx_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output sidx_pkg::result_t result
);
	import sidx_pkg::*;

	// front -> queue
	logic job_valid, job_ready;
	job_t job;

	// queue -> back
	logic q_valid, q_pop;
	job_t q_job;

	sidx_front #(
		.INDEX_WIDTH(INDEX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	sidx_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(job_valid),
		.push_ready(job_ready),
		.push_job  (job),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_job   (q_job)
	);

	sidx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (q_valid),
		.job_pop     (q_pop),
		.job         (q_job),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

// ===== hw/rtl/sidx_checker.sv =====
// ----------------------------------------------------------------------------
// sidx_checker: port-level checks for the slice index normalizer
// Watches the result channel; bound to the top level below.
// ----------------------------------------------------------------------------
module sidx_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input sidx_pkg::result_t result
);
	import sidx_pkg::*;

	// a held result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result dropped or changed while stalled");

	// error words carry nothing but the code
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.error_code != ERR_OK)
		|-> (result.element_count == '0) && (result.norm_start == '0)
		&& (result.norm_step == '0) && !result.stop_is_default)
		else $error("error word with nonzero fields");

	// good index words (step shown as zero) count exactly one element
	a_index_one: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.error_code == ERR_OK) && (result.norm_step == '0)
		|-> (result.element_count == CNT_W'(1)))
		else $error("index word count is not one");

	// default stop flag only with a stop of -1 and a negative step
	a_stop_default: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.stop_is_default
		|-> (result.norm_stop == 32'hFFFF_FFFF) && result.norm_step[VAL_W-1])
		else $error("default stop flag inconsistent");

endmodule

bind slice_index_normalizer sidx_checker u_sidx_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);
